// ----- design/mecanum_wheel_mixer_normalized_defines.svh -----
// Assertion helpers for the mecanum mixer checker.
`ifndef MECANUM_WHEEL_MIXER_NORMALIZED_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_NORMALIZED_DEFINES_SVH

// Checked only outside reset.
`define MWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MWM_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mwm_pkg.sv -----
package mwm_pkg;

  // register file
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_ROT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_DIST = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX  = 2'd2;

  localparam int ROT_W  = 15;
  localparam int DIST_W = 16;
  localparam int MAX_W  = 15;

  localparam logic signed [ROT_W-1:0] ROT_RST  = 15'sd0;
  localparam logic [DIST_W-1:0]       DIST_RST = 16'd13107;
  localparam logic [MAX_W-1:0]        MAX_RST  = 15'd16384;

  // datapath widths
  localparam int SPD_W  = 16;   // Q3.12 speeds
  localparam int COEF_W = 17;   // (+-s - 1) in Q1.14
  localparam int P1_W   = 33;   // coef * d
  localparam int P2_W   = 48;   // coef * d * wz
  localparam int MAG_W  = 47;
  localparam int ROT_TW = 18;   // rounded rotation term, signed
  localparam int WSUM_W = 19;   // wheel sums, signed
  localparam int ABS_W  = 17;   // wheel magnitude
  localparam int NUM_W  = ABS_W + MAX_W;
  localparam int QUO_W  = MAX_W;

  localparam int ROUND_SHIFT = 30;
  localparam logic signed [COEF_W-1:0] ONE_Q14    = 17'sd16384;
  localparam logic [P2_W-1:0]          ROUND_HALF = 48'd1 << (ROUND_SHIFT - 1);

  localparam int NWHEEL = 4;

  // pipeline layout
  localparam int PRE_STAGES = 7;
  localparam int DIV_STEPS  = QUO_W;
  localparam int NSTG       = PRE_STAGES + DIV_STEPS + 1;
  localparam int ST_OUT     = NSTG - 1;

  typedef struct packed {
    logic [NUM_W-1:0]        rem;
    logic [QUO_W-1:0]        quo;
    logic                    neg;
    logic signed [SPD_W-1:0] wlo;
  } div_lane_t;

endpackage

// ----- design/mecanum_wheel_mixer_normalized.sv -----
// Throughput is one command per cycle while the output keeps up. Seven stages of mixing and
// peak search feed a 15-stage restoring divider, one quotient bit per stage, four lanes
// side by side; a stall holds only the stages that are full.
// Reset (rst_n low, synchronous) empties the pipeline and restores the register defaults.
module mecanum_wheel_mixer_normalized (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mwm_pkg::SPD_W-1:0]    in_forward_speed,
  input  logic signed [mwm_pkg::SPD_W-1:0]    in_side_speed,
  input  logic signed [mwm_pkg::SPD_W-1:0]    in_yaw_rate,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mwm_pkg::SPD_W-1:0]    out_wheel_front_left,
  output logic signed [mwm_pkg::SPD_W-1:0]    out_wheel_front_right,
  output logic signed [mwm_pkg::SPD_W-1:0]    out_wheel_rear_right,
  output logic signed [mwm_pkg::SPD_W-1:0]    out_wheel_rear_left,
  output logic                                out_speed_limited,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mwm_pkg::ADDR_W-1:0]          paddr,
  input  logic [mwm_pkg::DATA_W-1:0]          pwdata,
  output logic [mwm_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);
  import mwm_pkg::*;

  // ---------------------------------------------------------------- registers
  logic signed [ROT_W-1:0] rot_scale_r;
  logic [DIST_W-1:0]       dist_r;
  logic [MAX_W-1:0]        max_r;
  logic [IDX_W-1:0]        reg_idx;

  assign reg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_scale_r <= ROT_RST;
      dist_r      <= DIST_RST;
      max_r       <= MAX_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ROT:  rot_scale_r <= pwdata[ROT_W-1:0];
        REG_DIST: dist_r      <= pwdata[DIST_W-1:0];
        REG_MAX:  max_r       <= pwdata[MAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROT:  prdata = {{(DATA_W-ROT_W){rot_scale_r[ROT_W-1]}}, rot_scale_r};
      REG_DIST: prdata = {{(DATA_W-DIST_W){1'b0}}, dist_r};
      REG_MAX:  prdata = {{(DATA_W-MAX_W){1'b0}}, max_r};
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // A stage loads when it is empty or its content moves on; bubbles collapse.
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  for (genvar k = 0; k < NSTG; k++) begin : g_en
    if (k == NSTG - 1) begin : g_last
      assign en[k] = !v_r[k] || out_ready;
    end else begin : g_mid
      assign en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: coef * d
  logic signed [COEF_W-1:0]   rot_ext, coef_f, coef_r, dist_s;
  logic signed [2*COEF_W-1:0] pf_full, pr_full;

  assign rot_ext = {{(COEF_W-ROT_W){rot_scale_r[ROT_W-1]}}, rot_scale_r};
  assign coef_f  = rot_ext - ONE_Q14;
  assign coef_r  = -rot_ext - ONE_Q14;
  assign dist_s  = {1'b0, dist_r};
  assign pf_full = (2*COEF_W)'(coef_f) * (2*COEF_W)'(dist_s);
  assign pr_full = (2*COEF_W)'(coef_r) * (2*COEF_W)'(dist_s);

  logic signed [P1_W-1:0]  s1_pf_r, s1_pr_r;
  logic signed [SPD_W-1:0] s1_vx_r, s1_vy_r, s1_wz_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_pf_r <= pf_full[P1_W-1:0];
      s1_pr_r <= pr_full[P1_W-1:0];
      s1_vx_r <= in_forward_speed;
      s1_vy_r <= in_side_speed;
      s1_wz_r <= in_yaw_rate;
    end
  end

  // ---------------------------------------------------------------- stage 2: * wz
  logic signed [P1_W+SPD_W-1:0] pf2_full, pr2_full;

  assign pf2_full = (P1_W+SPD_W)'(s1_pf_r) * (P1_W+SPD_W)'(s1_wz_r);
  assign pr2_full = (P1_W+SPD_W)'(s1_pr_r) * (P1_W+SPD_W)'(s1_wz_r);

  logic signed [P2_W-1:0]  s2_pf_r, s2_pr_r;
  logic signed [SPD_W-1:0] s2_vx_r, s2_vy_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_pf_r <= pf2_full[P2_W-1:0];
      s2_pr_r <= pr2_full[P2_W-1:0];
      s2_vx_r <= s1_vx_r;
      s2_vy_r <= s1_vy_r;
    end
  end

  // ---------------------------------------------------------------- stage 3: magnitude
  logic signed [P2_W-1:0] pf_neg, pr_neg;

  assign pf_neg = -s2_pf_r;
  assign pr_neg = -s2_pr_r;

  logic [MAG_W-1:0]        s3_mag_f_r, s3_mag_r_r;
  logic                    s3_neg_f_r, s3_neg_r_r;
  logic signed [SPD_W-1:0] s3_vx_r, s3_vy_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_neg_f_r <= s2_pf_r[P2_W-1];
      s3_neg_r_r <= s2_pr_r[P2_W-1];
      s3_mag_f_r <= s2_pf_r[P2_W-1] ? pf_neg[MAG_W-1:0] : s2_pf_r[MAG_W-1:0];
      s3_mag_r_r <= s2_pr_r[P2_W-1] ? pr_neg[MAG_W-1:0] : s2_pr_r[MAG_W-1:0];
      s3_vx_r    <= s2_vx_r;
      s3_vy_r    <= s2_vy_r;
    end
  end

  // ---------------------------------------------------------------- stage 4: round to Q3.12
  // half away from zero: round the magnitude, then restore the sign
  logic [P2_W-1:0]          rs_f, rs_r;
  logic signed [ROT_TW-1:0] rf_ext, rr_ext;

  assign rs_f   = {1'b0, s3_mag_f_r} + ROUND_HALF;
  assign rs_r   = {1'b0, s3_mag_r_r} + ROUND_HALF;
  assign rf_ext = {1'b0, rs_f[ROUND_SHIFT+ROT_TW-2:ROUND_SHIFT]};
  assign rr_ext = {1'b0, rs_r[ROUND_SHIFT+ROT_TW-2:ROUND_SHIFT]};

  logic signed [ROT_TW-1:0] s4_rot_f_r, s4_rot_r_r;
  logic signed [SPD_W-1:0]  s4_vx_r, s4_vy_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_rot_f_r <= s3_neg_f_r ? -rf_ext : rf_ext;
      s4_rot_r_r <= s3_neg_r_r ? -rr_ext : rr_ext;
      s4_vx_r    <= s3_vx_r;
      s4_vy_r    <= s3_vy_r;
    end
  end

  // ---------------------------------------------------------------- stage 5: wheel sums
  logic signed [WSUM_W-1:0] vx_x, vy_x, rf_x, rr_x;
  logic signed [WSUM_W-1:0] w_nxt [NWHEEL];

  assign vx_x = {{(WSUM_W-SPD_W){s4_vx_r[SPD_W-1]}}, s4_vx_r};
  assign vy_x = {{(WSUM_W-SPD_W){s4_vy_r[SPD_W-1]}}, s4_vy_r};
  assign rf_x = {{(WSUM_W-ROT_TW){s4_rot_f_r[ROT_TW-1]}}, s4_rot_f_r};
  assign rr_x = {{(WSUM_W-ROT_TW){s4_rot_r_r[ROT_TW-1]}}, s4_rot_r_r};

  assign w_nxt[0] =  vx_x - vy_x + rf_x;
  assign w_nxt[1] = -vx_x - vy_x + rf_x;
  assign w_nxt[2] = -vx_x + vy_x + rr_x;
  assign w_nxt[3] =  vx_x + vy_x + rr_x;

  logic signed [WSUM_W-1:0] s5_w_r [NWHEEL];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < NWHEEL; i++) s5_w_r[i] <= w_nxt[i];
    end
  end

  // ---------------------------------------------------------------- stage 6: abs, pair max
  logic signed [WSUM_W-1:0] wn [NWHEEL];
  logic [ABS_W-1:0]         a_nxt [NWHEEL];

  always_comb begin
    for (int i = 0; i < NWHEEL; i++) begin
      wn[i]    = -s5_w_r[i];
      a_nxt[i] = s5_w_r[i][WSUM_W-1] ? wn[i][ABS_W-1:0] : s5_w_r[i][ABS_W-1:0];
    end
  end

  logic signed [WSUM_W-1:0] s6_w_r [NWHEEL];
  logic [ABS_W-1:0]         s6_a_r [NWHEEL];
  logic [ABS_W-1:0]         s6_m01_r, s6_m23_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < NWHEEL; i++) begin
        s6_w_r[i] <= s5_w_r[i];
        s6_a_r[i] <= a_nxt[i];
      end
      s6_m01_r <= (a_nxt[0] > a_nxt[1]) ? a_nxt[0] : a_nxt[1];
      s6_m23_r <= (a_nxt[2] > a_nxt[3]) ? a_nxt[2] : a_nxt[3];
    end
  end

  // ---------------------------------------------------------------- stage 7: peak, |w| * max
  logic [ABS_W-1:0] peak;
  logic             limited;

  assign peak    = (s6_m01_r > s6_m23_r) ? s6_m01_r : s6_m23_r;
  assign limited = peak > {{(ABS_W-MAX_W){1'b0}}, max_r};

  // index 0 holds the dividend; index j+1 is the lane after divider step j
  div_lane_t        dl_r  [DIV_STEPS+1][NWHEEL];
  logic [ABS_W-1:0] dpk_r [DIV_STEPS+1];
  logic             dlim_r[DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en[PRE_STAGES-1]) begin
      for (int i = 0; i < NWHEEL; i++) begin
        dl_r[0][i].rem <= NUM_W'(s6_a_r[i]) * NUM_W'(max_r);
        dl_r[0][i].quo <= '0;
        dl_r[0][i].neg <= s6_w_r[i][WSUM_W-1];
        dl_r[0][i].wlo <= s6_w_r[i][SPD_W-1:0];
      end
      dpk_r[0]  <= peak;
      dlim_r[0] <= limited;
    end
  end

  // ---------------------------------------------------------------- divider steps
  // |w| <= peak and max < 2^15, so the quotient always fits QUO_W bits
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int BIT = DIV_STEPS - 1 - j;

    logic [NUM_W-1:0] dsh;
    div_lane_t        lane_nxt [NWHEEL];

    assign dsh = {{(NUM_W-ABS_W){1'b0}}, dpk_r[j]} << BIT;

    always_comb begin
      logic [NUM_W:0] trial;
      for (int i = 0; i < NWHEEL; i++) begin
        lane_nxt[i] = dl_r[j][i];
        trial       = {1'b0, dl_r[j][i].rem} - {1'b0, dsh};
        if (!trial[NUM_W]) begin
          lane_nxt[i].rem      = trial[NUM_W-1:0];
          lane_nxt[i].quo[BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[PRE_STAGES+j]) begin
        for (int i = 0; i < NWHEEL; i++) dl_r[j+1][i] <= lane_nxt[i];
        dpk_r[j+1]  <= dpk_r[j];
        dlim_r[j+1] <= dlim_r[j];
      end
    end
  end

  // ---------------------------------------------------------------- output register
  logic signed [SPD_W-1:0] q_pos [NWHEEL];
  logic signed [SPD_W-1:0] o_nxt [NWHEEL];

  always_comb begin
    for (int i = 0; i < NWHEEL; i++) begin
      q_pos[i] = {{(SPD_W-QUO_W){1'b0}}, dl_r[DIV_STEPS][i].quo};
      if (dlim_r[DIV_STEPS]) begin
        o_nxt[i] = dl_r[DIV_STEPS][i].neg ? -q_pos[i] : q_pos[i];
      end else begin
        o_nxt[i] = dl_r[DIV_STEPS][i].wlo;
      end
    end
  end

  logic signed [SPD_W-1:0] out_w_r [NWHEEL];
  logic                    out_lim_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      for (int i = 0; i < NWHEEL; i++) out_w_r[i] <= o_nxt[i];
      out_lim_r <= dlim_r[DIV_STEPS];
    end
  end

  assign out_wheel_front_left  = out_w_r[0];
  assign out_wheel_front_right = out_w_r[1];
  assign out_wheel_rear_right  = out_w_r[2];
  assign out_wheel_rear_left   = out_w_r[3];
  assign out_speed_limited     = out_lim_r;

endmodule

// ----- design/mwm_checker.sv -----
`include "mecanum_wheel_mixer_normalized_defines.svh"

module mwm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [mwm_pkg::SPD_W-1:0] out_wheel_front_left,
  input logic signed [mwm_pkg::SPD_W-1:0] out_wheel_front_right,
  input logic signed [mwm_pkg::SPD_W-1:0] out_wheel_rear_right,
  input logic signed [mwm_pkg::SPD_W-1:0] out_wheel_rear_left,
  input logic                             out_speed_limited
);
  import mwm_pkg::*;

  localparam logic [SPD_W-1:0] SPD_MOST_NEG = {1'b1, {(SPD_W-1){1'b0}}};

  // a stalled result beat keeps its valid and its payload
  `MWM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_wheel_front_left) && $stable(out_wheel_front_right) && $stable(out_wheel_rear_right) && $stable(out_wheel_rear_left) && $stable(out_speed_limited), "result beat changed while stalled")

  // input backpressure only comes from a stalled output
  `MWM_ASSERT(a_ready_cause, !in_ready |-> out_valid && !out_ready, "in_ready low without output stall")

  // every wheel stays within the limit, which is below the most negative code
  `MWM_ASSERT(a_wheel_range, out_valid |-> out_wheel_front_left != SPD_MOST_NEG && out_wheel_front_right != SPD_MOST_NEG && out_wheel_rear_right != SPD_MOST_NEG && out_wheel_rear_left != SPD_MOST_NEG, "wheel setpoint out of range")

  // reset empties the pipeline
  `MWM_ASSERT_ANY(a_reset_flush, !rst_n |=> !out_valid, "out_valid after reset")

endmodule

bind mecanum_wheel_mixer_normalized mwm_checker u_mwm_checker (.*);

// ----- bench/testbench.sv -----
module testbench;
  import mwm_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind this index
  localparam int PIPE_LATENCY = 23;
  localparam int CMDS_PER_PHASE = 225;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic signed [SPD_W-1:0] fl;
    logic signed [SPD_W-1:0] fr;
    logic signed [SPD_W-1:0] rr;
    logic signed [SPD_W-1:0] rl;
    logic                    limited;
  } wheel_set_t;

  class wheel_scoreboard;
    longint rot_scale;
    longint wheel_dist;
    longint speed_cap;
    wheel_set_t expected_wheels[$];
    int errors;
    int checked;
    int limited_seen;
    int commands;

    function new();
      rot_scale = longint'(ROT_RST);
      wheel_dist = longint'(DIST_RST);
      speed_cap = longint'(MAX_RST);
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_ROT:  rot_scale = longint'($signed(val[ROT_W-1:0]));
        REG_DIST: wheel_dist = longint'(val[DIST_W-1:0]);
        REG_MAX:  speed_cap = longint'(val[MAX_W-1:0]);
        default: ;
      endcase
    endfunction

    // coef (Q1.14) * d (Q0.16) * wz (Q3.12) back to Q3.12, ties away from zero
    function longint rotation_term(longint coef, longint wz);
      longint p, mag, r;
      p = coef * wheel_dist * wz;
      mag = (p < 0) ? -p : p;
      r = (mag + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      return (p < 0) ? -r : r;
    endfunction

    function wheel_set_t mix_wheels(logic signed [SPD_W-1:0] fwd,
                                    logic signed [SPD_W-1:0] side,
                                    logic signed [SPD_W-1:0] yaw);
      longint vx, vy, wz, front, rear, peak, mag;
      longint w[4];
      wheel_set_t r;
      vx = longint'(fwd);
      vy = longint'(side);
      wz = longint'(yaw);
      front = rotation_term(rot_scale - longint'(ONE_Q14), wz);
      rear = rotation_term(-rot_scale - longint'(ONE_Q14), wz);
      w[0] = vx - vy + front;
      w[1] = -vx - vy + front;
      w[2] = -vx + vy + rear;
      w[3] = vx + vy + rear;
      peak = 0;
      foreach (w[i]) begin
        mag = (w[i] < 0) ? -w[i] : w[i];
        if (mag > peak) peak = mag;
      end
      r.limited = (peak > speed_cap);
      if (r.limited) begin
        foreach (w[i]) w[i] = (w[i] * speed_cap) / peak;  // truncates toward zero
      end
      r.fl = w[0][SPD_W-1:0];
      r.fr = w[1][SPD_W-1:0];
      r.rr = w[2][SPD_W-1:0];
      r.rl = w[3][SPD_W-1:0];
      return r;
    endfunction

    function void note_command(logic signed [SPD_W-1:0] fwd,
                               logic signed [SPD_W-1:0] side,
                               logic signed [SPD_W-1:0] yaw);
      expected_wheels.push_back(mix_wheels(fwd, side, yaw));
      commands++;
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_wheels(logic signed [SPD_W-1:0] fl, logic signed [SPD_W-1:0] fr,
                               logic signed [SPD_W-1:0] rr, logic signed [SPD_W-1:0] rl,
                               logic limited);
      wheel_set_t e;
      if (expected_wheels.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %0d %0d %0d %0d limited %0d",
                 $time, fl, fr, rr, rl, limited);
        errors++;
        return;
      end
      e = expected_wheels.pop_front();
      checked++;
      if (e.limited) limited_seen++;
      compare("wheel_front_left", int'(e.fl), int'(fl));
      compare("wheel_front_right", int'(e.fr), int'(fr));
      compare("wheel_rear_right", int'(e.rr), int'(rr));
      compare("wheel_rear_left", int'(e.rl), int'(rl));
      compare("speed_limited", int'(e.limited), int'(limited));
    endfunction

    function int pending();
      return expected_wheels.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [SPD_W-1:0] in_forward_speed;
  logic signed [SPD_W-1:0] in_side_speed;
  logic signed [SPD_W-1:0] in_yaw_rate;
  logic out_valid;
  logic out_ready;
  logic signed [SPD_W-1:0] out_wheel_front_left;
  logic signed [SPD_W-1:0] out_wheel_front_right;
  logic signed [SPD_W-1:0] out_wheel_rear_right;
  logic signed [SPD_W-1:0] out_wheel_rear_left;
  logic out_speed_limited;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  int hold_left;
  int cfg_writes;
  wheel_scoreboard sb = new();

  mecanum_wheel_mixer_normalized u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_forward_speed      (in_forward_speed),
    .in_side_speed         (in_side_speed),
    .in_yaw_rate           (in_yaw_rate),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_wheel_front_left  (out_wheel_front_left),
    .out_wheel_front_right (out_wheel_front_right),
    .out_wheel_rear_right  (out_wheel_rear_right),
    .out_wheel_rear_left   (out_wheel_rear_left),
    .out_speed_limited     (out_speed_limited),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_command(in_forward_speed, in_side_speed, in_yaw_rate);
      if (out_valid && out_ready)
        sb.check_wheels(out_wheel_front_left, out_wheel_front_right, out_wheel_rear_right,
                        out_wheel_rear_left, out_speed_limited);
    end
  end

  // result side: random stall patterns that change from time to time, plus a long hold-off
  initial begin : rx_pattern
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = ($urandom_range(0, 4) == 0);
          default: out_ready = ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  function automatic logic [DATA_W-1:0] reg_word(logic [DATA_W-1:0] v, int width);
    logic [DATA_W-1:0] m;
    m = (32'd1 << width) - 1;
    return (DATA_W'($urandom) & ~m) | (v & m);  // junk above the field
  endfunction

  function automatic logic signed [SPD_W-1:0] pick_speed();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      1, 2, 3, 4: return SPD_W'($urandom);
      default: return SPD_W'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_cmd(logic signed [SPD_W-1:0] fwd, logic signed [SPD_W-1:0] side,
                          logic signed [SPD_W-1:0] yaw);
    @(negedge clk);
    in_valid = 1'b1;
    in_forward_speed = fwd;
    in_side_speed = side;
    in_yaw_rate = yaw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic stream_random(int n);
    int left, burst, gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        send_cmd(pick_speed(), pick_speed(), pick_speed());
        left--;
      end
      // keep offering back to back while the result side is held off
      gap = (hold_left > 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  initial begin : main_seq
    int ph;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_forward_speed = '0;
    in_side_speed = '0;
    in_yaw_rate = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_left = 0;
    cfg_writes = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) drain();
      case (ph)
        0: begin
          // reset settings
          send_cmd(0, 0, 0);
          send_cmd(32767, 32767, 32767);
          send_cmd(-32768, -32768, -32768);
          send_cmd(32767, -32768, 0);
          send_cmd(-32768, 32767, 0);
          send_cmd(16384, 0, 0);   // peak sits right on the limit
          send_cmd(16385, 0, 0);
          send_cmd(0, -16384, 0);
          send_cmd(0, 0, 32767);
          send_cmd(0, 0, -32768);
          send_cmd(1, -1, 1);
          send_cmd(4096, -4096, 4096);
        end
        1: begin
          cfg_write(REG_ROT, reg_word(32'h0000_4000, ROT_W));   // -1.0
          cfg_write(REG_DIST, reg_word(32'h0000_FFFF, DIST_W));
          cfg_write(REG_MAX, reg_word(32'd1, MAX_W));
          send_cmd(0, 0, 0);
          send_cmd(1, 0, 0);
          send_cmd(2, 0, 0);
          send_cmd(0, 0, 32767);
          send_cmd(0, 0, -32768);
        end
        2: begin
          cfg_write(REG_ROT, reg_word(32'h0000_3FFF, ROT_W));
          cfg_write(REG_DIST, reg_word(32'd0, DIST_W));
          cfg_write(REG_MAX, reg_word(32'd32767, MAX_W));
          send_cmd(32767, -32768, 5);
          send_cmd(-32768, 32767, -5);
        end
        3: begin
          // zero limit: any nonzero command scales to all zeros
          cfg_write(REG_ROT, $urandom);
          cfg_write(REG_DIST, $urandom);
          cfg_write(REG_MAX, reg_word(32'd0, MAX_W));
          send_cmd(0, 0, 0);
          send_cmd(3, 0, 0);
          send_cmd(0, -1, 0);
        end
        4: begin
          // d = 0.5 puts odd yaw rates exactly on a rounding tie
          cfg_write(REG_ROT, reg_word(32'd0, ROT_W));
          cfg_write(REG_DIST, reg_word(32'd32768, DIST_W));
          cfg_write(REG_MAX, reg_word(32'd32767, MAX_W));
          send_cmd(0, 0, 1);
          send_cmd(0, 0, -1);
          send_cmd(0, 0, 3);
        end
        5: begin
          cfg_write(REG_ROT, $urandom);
          cfg_write(REG_DIST, $urandom);
          cfg_write(REG_MAX, reg_word($urandom_range(1, 32767), MAX_W));
          cfg_write(REG_SPARE, $urandom);  // must not disturb the others
          hold_left = 300;
        end
        default: begin
          cfg_write(REG_ROT, $urandom);
          cfg_write(REG_DIST, $urandom);
          cfg_write(REG_MAX, reg_word($urandom_range(1, 32767), MAX_W));
        end
      endcase
      stream_random(CMDS_PER_PHASE);
    end
    drain();

    $display("Ran %0d commands across %0d register settings (%0d register writes).",
             sb.commands, NUM_PHASES, cfg_writes);
    $display("Checked %0d wheel sets, %0d of them scaled to the speed limit; %0d errors.",
             sb.checked, sb.limited_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("%0t: timed out with %0d wheel sets outstanding", $time, sb.pending());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/mwm_pkg.sv
design/mecanum_wheel_mixer_normalized.sv
design/mwm_checker.sv
bench/testbench.sv
